@@ hw/rtl/pcc_pkg.sv @@
`timescale 1ns / 1ps

package pcc_pkg;

   localparam int EntryCount  = 256;
   localparam int IndexWidth  = 8;
   localparam int InWidth     = 6;
   localparam int ColorWidth  = 8;
   localparam int EntryWidth  = 3 * ColorWidth;
   localparam int FastOffBits = 3;
   localparam int SlowOffBits = 2;

   localparam logic [1:0] LowFill = 2'b11;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef struct packed {
      action_type            action;
      logic [IndexWidth-1:0] entry_index;
      logic [InWidth-1:0]    red_in;
      logic [InWidth-1:0]    green_in;
      logic [InWidth-1:0]    blue_in;
   } req_type;

   typedef struct packed {
      logic [ColorWidth-1:0] red_out;
      logic [ColorWidth-1:0] green_out;
      logic [ColorWidth-1:0] blue_out;
   } rsp_type;

   // 6-bit component to 8 bits: zero stays zero, else low bits filled
   function automatic logic [ColorWidth-1:0] widen6(input logic [InWidth-1:0] v);
      logic [ColorWidth-1:0] w;
      if (v == '0) begin
         w = '0;
      end else begin
         w = {v, LowFill};
      end
      return w;
   endfunction

endpackage

@@ hw/rtl/pcc_ram.sv @@
`timescale 1ns / 1ps

module pcc_ram #(
   parameter int Width = 24,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/pcc_cycler.sv @@
`timescale 1ns / 1ps

module pcc_cycler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           tick,
   input  logic [pcc_pkg::IndexWidth-1:0] logical_index,
   output logic [pcc_pkg::IndexWidth-1:0] physical_index
);

   import pcc_pkg::*;

   logic [FastOffBits-1:0] fast_off_ff, fast_off_in;
   logic [SlowOffBits-1:0] slow_off_ff, slow_off_in;
   logic                   slow_phase_ff, slow_phase_in;

   // rotation offsets: a tick moves the fast ranges down by one place; the slow ranges move on every second tick
   always_comb begin
      fast_off_in   = fast_off_ff;
      slow_off_in   = slow_off_ff;
      slow_phase_in = slow_phase_ff;
      if (tick) begin
         fast_off_in   = fast_off_ff + 1'b1;
         slow_phase_in = ~slow_phase_ff;
         if (slow_phase_ff) begin
            slow_off_in = slow_off_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_off_ff   <= '0;
         slow_off_ff   <= '0;
         slow_phase_ff <= 1'b1;
      end else begin
         fast_off_ff   <= fast_off_in;
         slow_off_ff   <= slow_off_in;
         slow_phase_ff <= slow_phase_in;
      end
   end

   // logical to physical entry: offset added modulo the range length
   always_comb begin
      physical_index = logical_index;
      if (logical_index[7:4] == 4'hE) begin
         physical_index = {logical_index[7:3], logical_index[2:0] + fast_off_ff};
      end else if (logical_index[7:4] == 4'hF && logical_index[3:2] != 2'b11) begin
         physical_index = {logical_index[7:2], logical_index[1:0] + slow_off_ff};
      end
   end

endmodule

@@ hw/rtl/palette_ram_with_color_cycling_top.sv @@
`timescale 1ns / 1ps

// Palette RAM with color cycling: 256 entries of 8-bit red, green and blue.
// Request channel (req_valid/req_ready/req_payload) carries one transaction:
// write an entry from 6-bit components, frame tick, or read an entry.
// Response channel (rsp_valid/rsp_ready/rsp_payload) returns one transaction
// per read; writes, ticks and the unused action code return nothing.
// Color cycling is done with rotation offsets applied to the entry index, so
// a frame tick never walks the RAM.
// Writes and ticks are taken one per cycle while req_ready is high. A read is
// issued to the RAM port at the edge it is accepted; its data passes from the
// RAM read register into the output register, which drives rsp_valid. No
// request is taken while the RAM read data is in flight, so a new read is
// not taken until the previous one has reached the output register. The
// single registered RAM read port sets that limit.
// When the receiver stalls, the response holds in the output register and
// req_ready drops until it is taken.
// Reset clears the rotation offsets, sets the slow-range phase and empties
// the output register; RAM contents are undefined until written and no
// clearing pass is run.
module palette_ram_with_color_cycling_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pcc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pcc_pkg::rsp_type rsp_payload
);

   import pcc_pkg::*;

   logic                  req_fire;
   logic                  is_write;
   logic                  is_tick;
   logic                  is_read;
   logic [IndexWidth-1:0] phys_index;
   logic [EntryWidth-1:0] wr_data;
   logic [EntryWidth-1:0] rd_data;

   logic    rd_pend_ff, rd_pend_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   // request decode
   assign req_ready = !rd_pend_ff && (!out_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign is_write  = req_fire && (req_payload.action == ACT_WRITE);
   assign is_tick   = req_fire && (req_payload.action == ACT_TICK);
   assign is_read   = req_fire && (req_payload.action == ACT_READ);

   // rotation offsets and index mapping
   pcc_cycler u_cycler (
      .clock          (clock),
      .reset          (reset),
      .tick           (is_tick),
      .logical_index  (req_payload.entry_index),
      .physical_index (phys_index)
   );

   // widened color for a write
   assign wr_data = {widen6(req_payload.red_in),
                     widen6(req_payload.green_in),
                     widen6(req_payload.blue_in)};

   pcc_ram #(
      .Width (EntryWidth),
      .Depth (EntryCount)
   ) u_ram (
      .clock   (clock),
      .wr_en   (is_write),
      .wr_addr (phys_index),
      .wr_data (wr_data),
      .rd_en   (is_read),
      .rd_addr (phys_index),
      .rd_data (rd_data)
   );

   // read tracking and output register
   always_comb begin
      rd_pend_in   = is_read;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (rd_pend_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         out_data_ff <= rd_data;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

@@ hw/rtl/pcc_checker.sv @@
`timescale 1ns / 1ps

module pcc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input pcc_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pcc_pkg::rsp_type rsp_payload
);

   import pcc_pkg::*;

   logic read_fire;
   logic other_fire;

   assign read_fire  = req_valid && req_ready && (req_payload.action == ACT_READ);
   assign other_fire = req_valid && req_ready && (req_payload.action != ACT_READ);

   // stalled response holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   // every read transaction is offered a response
   assert property (@(posedge clock) disable iff (reset)
      read_fire |-> ##2 rsp_valid)
      else $error("read transaction produced no response");

   // a response only appears for a read
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(read_fire, 2))
      else $error("response without a read transaction");

   // writes, ticks and the unused action code produce no response
   assert property (@(posedge clock) disable iff (reset)
      other_fire && !rsp_valid |=> !rsp_valid ##1 !rsp_valid)
      else $error("response after a write or tick transaction");

   // reset empties the response channel
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind palette_ram_with_color_cycling_top pcc_checker u_pcc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
